// ===== rtl/lzm_pkg.sv =====
// lzm_pkg: shared constants, types and the reciprocal table of the local zoom magnifier
// no dependencies; imported by lzm_ctrl, lzm_datapath and local_zoom_magnifier
`timescale 1ns / 1ps
`default_nettype none

package lzm_pkg;

    // frame store geometry
    localparam int MAX_COLS    = 256;
    localparam int MAX_ROWS    = 256;
    localparam int CIDX_W      = $clog2(MAX_COLS);
    localparam int RIDX_W      = $clog2(MAX_ROWS);
    localparam int ADDR_W      = CIDX_W + RIDX_W;
    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;

    // image size width: holds the largest size and the 9 bit register
    localparam int SZ_MAX      = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
    localparam int SZ_W0       = $clog2(SZ_MAX + 1);
    localparam int SZ_W        = (SZ_W0 > 9) ? SZ_W0 : 9;

    // field widths
    localparam int COORD_W     = 8;
    localparam int COLOR_W     = 8;
    localparam int PIX_W       = 3 * COLOR_W;
    localparam int FACT_W      = 4;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 3;

    // datapath widths: half size below 128, offsets below 2048
    localparam int D_W         = 7;
    localparam int FD_W        = 11;
    localparam int U_W         = 12;
    localparam int K_W         = 11;
    localparam int RECIP_SH    = 18;
    localparam int RECIP_W     = RECIP_SH + 1;
    localparam int PROD_W      = K_W + RECIP_W;

    localparam logic [FACT_W-1:0] FACT_MAX = 4'd10;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM_FACTOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS   = 3'd5;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PARAM,
        ST_CENTER,
        ST_HALF,
        ST_SCALE,
        ST_OFFSET,
        ST_DIVIDE,
        ST_REMAIN,
        ST_MAP,
        ST_FETCH,
        ST_RESULT
    } lzm_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic take;
        logic store_wr;
        logic load_param;
        logic load_center;
        logic load_half;
        logic load_scale;
        logic load_offset;
        logic load_div;
        logic load_rem;
        logic load_map;
        logic fetch;
        logic load_out;
    } lzm_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic out_full;
    } lzm_status_t;

    // ceil(2^18 / f); exact quotient for dividends below 2048
    function automatic logic [RECIP_W-1:0] recip(input logic [FACT_W-1:0] f);
        logic [RECIP_W-1:0] r;
        begin
            unique case (f)
                4'd1:    r = 19'd262144;
                4'd2:    r = 19'd131072;
                4'd3:    r = 19'd87382;
                4'd4:    r = 19'd65536;
                4'd5:    r = 19'd52429;
                4'd6:    r = 19'd43691;
                4'd7:    r = 19'd37450;
                4'd8:    r = 19'd32768;
                4'd9:    r = 19'd29128;
                4'd10:   r = 19'd26215;
                default: r = 19'd262144;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lzm_ram.sv =====
// lzm_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lzm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lzm_ctrl.sv =====
// lzm_ctrl: state machine that sequences the zoom mapping of one read transfer
// depends on lzm_pkg
`timescale 1ns / 1ps
`default_nettype none

module lzm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic                in_kind,
    output logic                     in_ready,
    input  wire lzm_pkg::lzm_status_t status,
    output lzm_pkg::lzm_cmd_t        cmd
);

    import lzm_pkg::*;

    lzm_state_t state_reg;
    lzm_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_kind == KIND_READ)
                    begin
                        cmd.take   = 1'b1;
                        state_next = ST_PARAM;
                    end
                    else
                    begin
                        cmd.store_wr = 1'b1;
                    end
                end
            end
            ST_PARAM:
            begin
                cmd.load_param = 1'b1;
                state_next     = ST_CENTER;
            end
            ST_CENTER:
            begin
                cmd.load_center = 1'b1;
                state_next      = ST_HALF;
            end
            ST_HALF:
            begin
                cmd.load_half = 1'b1;
                state_next    = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.load_scale = 1'b1;
                state_next     = ST_OFFSET;
            end
            ST_OFFSET:
            begin
                cmd.load_offset = 1'b1;
                state_next      = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.load_div = 1'b1;
                state_next   = ST_REMAIN;
            end
            ST_REMAIN:
            begin
                cmd.load_rem = 1'b1;
                state_next   = ST_MAP;
            end
            ST_MAP:
            begin
                cmd.load_map = 1'b1;
                state_next   = ST_FETCH;
            end
            ST_FETCH:
            begin
                cmd.fetch  = 1'b1;
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                // wait for the output register to drain
                if (!status.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/lzm_datapath.sv =====
// lzm_datapath: configuration registers, zoom mapping arithmetic, frame store and
// output register; depends on lzm_pkg and lzm_ram
`timescale 1ns / 1ps
`default_nettype none

module lzm_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_wen,
    input  wire logic [lzm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lzm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [39:0]                         in_data,
    input  wire lzm_pkg::lzm_cmd_t                   cmd,
    output lzm_pkg::lzm_status_t                     status,
    output logic [23:0]                              out_data,
    output logic                                     out_win,
    output logic                                     out_valid,
    input  wire logic                                out_ready
);

    import lzm_pkg::*;

    // configuration registers
    logic [COORD_W-1:0] center_col_reg;
    logic [COORD_W-1:0] center_row_reg;
    logic [COORD_W-1:0] window_width_reg;
    logic [FACT_W-1:0]  zoom_factor_reg;
    logic [8:0]         image_cols_reg;
    logic [8:0]         image_rows_reg;

    // item and mapping registers
    logic [COORD_W-1:0] col_reg;
    logic [COORD_W-1:0] row_reg;
    logic               oob_reg;
    logic [SZ_W-1:0]    cols_reg;
    logic [SZ_W-1:0]    rows_reg;
    logic [FACT_W-1:0]  f_reg;
    logic [D_W-1:0]     hw_reg;
    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cy_reg;
    logic               in_img_reg;
    logic [D_W-1:0]     d_reg;
    logic [FD_W-1:0]    fd_reg;
    logic [U_W-1:0]     uc_reg;
    logic [U_W-1:0]     ur_reg;
    logic [K_W-1:0]     kc_reg;
    logic [K_W-1:0]     kr_reg;
    logic [K_W-1:0]     fkc_reg;
    logic [K_W-1:0]     fkr_reg;
    logic               win_reg;
    logic [COORD_W-1:0] sc_reg;
    logic [COORD_W-1:0] sr_reg;
    logic [PIX_W-1:0]   out_data_reg;
    logic               out_win_reg;
    logic               out_valid_reg;

    // combinational values
    logic [COORD_W-1:0] in_col;
    logic [COORD_W-1:0] in_row;
    logic [PIX_W-1:0]   in_pix;
    logic               in_oob;
    logic [SZ_W-1:0]    cols_c;
    logic [SZ_W-1:0]    rows_c;
    logic [FACT_W-1:0]  f_c;
    logic [SZ_W-1:0]    cols_m1;
    logic [SZ_W-1:0]    rows_m1;
    logic [COORD_W-1:0] cx_c;
    logic [COORD_W-1:0] cy_c;
    logic [SZ_W-1:0]    d_c;
    logic [SZ_W-1:0]    m_right;
    logic [SZ_W-1:0]    m_bottom;
    logic [SZ_W-1:0]    m_a;
    logic [SZ_W-1:0]    m_b;
    logic [PROD_W-1:0]  prod_c;
    logic [PROD_W-1:0]  prod_r;
    logic [RECIP_W-1:0] recip_f;
    logic [14:0]        fk_c;
    logic [14:0]        fk_r;
    logic               hit_c;
    logic               hit_r;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [PIX_W-1:0]   rd_data;

    // one axis of the block test: whole block inside the image and inside the window
    function automatic logic axis_hit(
        input logic [U_W-1:0]     u,
        input logic [K_W-1:0]     k,
        input logic [K_W-1:0]     fk,
        input logic [COORD_W-1:0] p,
        input logic [D_W-1:0]     d,
        input logic [FACT_W-1:0]  f,
        input logic [SZ_W-1:0]    size
    );
        logic [K_W-1:0]  rem;
        logic [SZ_W:0]   start;
        logic [SZ_W+1:0] block_end;
        logic            ok;
        begin
            rem       = u[K_W-1:0] - fk;
            start     = {1'b0, SZ_W'(p)} - (SZ_W+1)'(rem);
            block_end = (SZ_W+2)'(start) + (SZ_W+2)'(f);
            ok        = !u[U_W-1];
            ok        = ok && (k <= K_W'({d, 1'b0}));
            ok        = ok && !start[SZ_W];
            ok        = ok && (block_end <= (SZ_W+2)'(size));
            return ok;
        end
    endfunction

    // input field unpacking
    assign in_col = in_data[7:0];
    assign in_row = in_data[15:8];
    assign in_pix = in_data[39:16];
    assign in_oob = (32'(in_col) >= 32'(MAX_COLS)) || (32'(in_row) >= 32'(MAX_ROWS));

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_col_reg   <= 8'd128;
            center_row_reg   <= 8'd128;
            window_width_reg <= 8'd40;
            zoom_factor_reg  <= 4'd2;
            image_cols_reg   <= 9'd256;
            image_rows_reg   <= 9'd256;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_CENTER_COL:   center_col_reg   <= cfg_data[7:0];
                REG_CENTER_ROW:   center_row_reg   <= cfg_data[7:0];
                REG_WINDOW_WIDTH: window_width_reg <= cfg_data[7:0];
                REG_ZOOM_FACTOR:  zoom_factor_reg  <= cfg_data[3:0];
                REG_IMAGE_COLS:   image_cols_reg   <= cfg_data[8:0];
                REG_IMAGE_ROWS:   image_rows_reg   <= cfg_data[8:0];
                default:          ;
            endcase
        end
    end

    // saturated sizes and factor
    always_comb
    begin
        if (image_cols_reg == 9'd0)
            cols_c = SZ_W'(1);
        else if (SZ_W'(image_cols_reg) > SZ_W'(MAX_COLS))
            cols_c = SZ_W'(MAX_COLS);
        else
            cols_c = SZ_W'(image_cols_reg);
        if (image_rows_reg == 9'd0)
            rows_c = SZ_W'(1);
        else if (SZ_W'(image_rows_reg) > SZ_W'(MAX_ROWS))
            rows_c = SZ_W'(MAX_ROWS);
        else
            rows_c = SZ_W'(image_rows_reg);
        if (zoom_factor_reg == '0)
            f_c = FACT_W'(1);
        else if (zoom_factor_reg > FACT_MAX)
            f_c = FACT_MAX;
        else
            f_c = zoom_factor_reg;
    end

    // clamped center
    assign cols_m1 = cols_reg - SZ_W'(1);
    assign rows_m1 = rows_reg - SZ_W'(1);
    assign cx_c = (SZ_W'(center_col_reg) > cols_m1) ? cols_m1[COORD_W-1:0] : center_col_reg;
    assign cy_c = (SZ_W'(center_row_reg) > rows_m1) ? rows_m1[COORD_W-1:0] : center_row_reg;

    // half size as the minimum of five bounds
    assign m_right  = cols_m1 - SZ_W'(cx_reg);
    assign m_bottom = rows_m1 - SZ_W'(cy_reg);
    assign m_a      = (SZ_W'(cx_reg) < SZ_W'(cy_reg)) ? SZ_W'(cx_reg) : SZ_W'(cy_reg);
    assign m_b      = (m_right < m_bottom) ? m_right : m_bottom;
    always_comb
    begin
        d_c = SZ_W'(hw_reg);
        if (m_a < d_c)
            d_c = m_a;
        if (m_b < d_c)
            d_c = m_b;
    end

    // block index by reciprocal multiply, block offset by multiply back
    assign recip_f = recip(f_reg);
    assign prod_c  = PROD_W'(uc_reg[K_W-1:0]) * PROD_W'(recip_f);
    assign prod_r  = PROD_W'(ur_reg[K_W-1:0]) * PROD_W'(recip_f);
    assign fk_c    = 15'(f_reg) * 15'(kc_reg);
    assign fk_r    = 15'(f_reg) * 15'(kr_reg);

    // per-axis block test
    assign hit_c = axis_hit(uc_reg, kc_reg, fkc_reg, col_reg, d_reg, f_reg, cols_reg);
    assign hit_r = axis_hit(ur_reg, kr_reg, fkr_reg, row_reg, d_reg, f_reg, rows_reg);

    // mapping pipeline, one step per command
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            col_reg <= in_col;
            row_reg <= in_row;
            oob_reg <= in_oob;
        end
        if (cmd.load_param)
        begin
            cols_reg <= cols_c;
            rows_reg <= rows_c;
            f_reg    <= f_c;
            hw_reg   <= window_width_reg[COORD_W-1:1];
        end
        if (cmd.load_center)
        begin
            cx_reg     <= cx_c;
            cy_reg     <= cy_c;
            in_img_reg <= (SZ_W'(col_reg) < cols_reg) && (SZ_W'(row_reg) < rows_reg);
        end
        if (cmd.load_half)
        begin
            d_reg <= d_c[D_W-1:0];
        end
        if (cmd.load_scale)
        begin
            fd_reg <= FD_W'(f_reg) * FD_W'(d_reg);
        end
        if (cmd.load_offset)
        begin
            uc_reg <= U_W'(col_reg) - U_W'(cx_reg) + U_W'(fd_reg);
            ur_reg <= U_W'(row_reg) - U_W'(cy_reg) + U_W'(fd_reg);
        end
        if (cmd.load_div)
        begin
            kc_reg <= prod_c[RECIP_SH +: K_W];
            kr_reg <= prod_r[RECIP_SH +: K_W];
        end
        if (cmd.load_rem)
        begin
            fkc_reg <= fk_c[K_W-1:0];
            fkr_reg <= fk_r[K_W-1:0];
        end
        if (cmd.load_map)
        begin
            win_reg <= in_img_reg && hit_c && hit_r;
            sc_reg  <= cx_reg - COORD_W'(d_reg) + kc_reg[COORD_W-1:0];
            sr_reg  <= cy_reg - COORD_W'(d_reg) + kr_reg[COORD_W-1:0];
        end
    end

    // frame store addressing
    assign wr_addr = {RIDX_W'(in_row), CIDX_W'(in_col)};
    assign rd_addr = win_reg ? {RIDX_W'(sr_reg), CIDX_W'(sc_reg)}
                             : {RIDX_W'(row_reg), CIDX_W'(col_reg)};

    lzm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (cmd.store_wr && !in_oob),
        .wr_addr (wr_addr),
        .wr_data (in_pix),
        .rd_en   (cmd.fetch),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // output register, valid cleared on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= oob_reg ? '0 : rd_data;
            out_win_reg  <= oob_reg ? 1'b0 : win_reg;
        end
    end

    // stored pixel keeps the stream order, red lowest
    assign out_data        = out_data_reg;
    assign out_win         = out_win_reg;
    assign out_valid       = out_valid_reg;
    assign status.out_full = out_valid_reg;

endmodule

`default_nettype wire

// ===== rtl/local_zoom_magnifier.sv =====
// local_zoom_magnifier: top level of the pixel replication zoom block
// depends on lzm_pkg, lzm_ctrl, lzm_datapath and lzm_ram
// write transfer: stored at the accepting edge; next item accepted at once
// read transfer: after accept, eight mapping steps, a frame store read and an output load;
//   next item accepted once the result is loaded, later while a result still waits
// reset: asynchronous active low; registers return to 128, 128, 40, 2, 256, 256;
//   the frame store is not cleared and holds unknown data until written
`timescale 1ns / 1ps
`default_nettype none

module local_zoom_magnifier (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        cfg_wen,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [8:0]  cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // col, row, in_red, in_green, in_blue
    input  wire logic        s_axis_tuser,   // kind
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // out_red, out_green, out_blue
    output logic             m_axis_tuser    // in_window
);

    import lzm_pkg::*;

    lzm_cmd_t    cmd;
    lzm_status_t status;

    lzm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_kind  (s_axis_tuser),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lzm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .cmd       (cmd),
        .status    (status),
        .out_data  (m_axis_tdata),
        .out_win   (m_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready)
    );

    // a result never overwrites one still waiting
    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !status.out_full)
        else $error("result loaded over a pending one");

    // frame store writes only on an accepted write transfer
    a_write_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_wr |-> (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_WRITE))
        else $error("frame store write without write transfer");

    // an accepted read holds off further input
    a_read_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_READ) |=> !s_axis_tready)
        else $error("input accepted while a read is in progress");

    // a loaded result is presented on the next cycle
    a_result_shown : assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire
